FILE: sv/swpd_pkg.sv
// Shared types, codes and constants for the single-wire sensor pulse decoder.
package swpd_pkg;

  localparam int SENSOR_SLOTS       = 8;
  localparam int NUM_SENSORS_DEFAULT = 8;
  localparam int EDGE_TOTAL         = 5 * 8 + 3;
  localparam int EDGE_CNT_W         = 6;
  localparam int BITS_W             = 40;
  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 32;

  localparam logic [7:0]  THRESHOLD_RESET    = 8'd101;
  localparam logic [11:0] START_GAP_RESET    = 12'd500;
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd2100 * 32'd1000;
  localparam logic [7:0]  TEMP_MAG_MASK      = 8'h7F;
  localparam logic [7:0]  TEMP_SIGN_MASK     = 8'h80;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_TOO_SOON = 3'd2,
    ST_IO       = 3'd3,
    ST_BUSY     = 3'd4,
    ST_STARTED  = 3'd5
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE_MASK  = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_START_GAP    = 2'd2,
    REG_MIN_INTERVAL = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  sensor_slot;
    logic [31:0] time_us;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] humidity_tenths;
    logic [14:0] temperature_tenths;
    logic        temperature_negative;
  } result_t;

endpackage

FILE: sv/single_wire_sensor_pulse_decoder.sv
// Path: each item is held in the item register while decode logic forms its result,
// which is written into the result register once that register is free.
// Throughput: one item per cycle; an item moves on when the result register is
// free or being taken in the same cycle. Edge items give no result.
// Reset: synchronous; clears control state, configuration registers return to their defaults.
module single_wire_sensor_pulse_decoder
  import swpd_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic    stage_valid;
  item_t   stage_item;
  logic    go;
  logic    has_result;
  result_t result_next;

  // the stage advances when the result slot is empty or drains this cycle
  assign go         = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || go;

  swpd_core #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .go         (go),
    .item       (stage_item),
    .has_result (has_result),
    .result_next(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= has_result;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_result) begin
      result <= result_next;
    end
  end

endmodule

FILE: sv/swpd_core.sv
// Decoder state, configuration registers and per-item decision logic.
module swpd_core
  import swpd_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   go,
  input  item_t                  item,
  output logic                   has_result,
  output result_t                result_next
);

  logic [NUM_SENSORS-1:0] enable_mask;
  logic [7:0]             one_bit_threshold;
  logic [11:0]            start_gap;
  logic [31:0]            min_interval;

  logic                  collecting, collecting_next;
  logic [2:0]            active_sensor, active_sensor_next;
  logic [31:0]           start_time, start_time_next;
  logic [EDGE_CNT_W-1:0] edge_count, edge_count_next;
  logic [31:0]           previous_edge_time, previous_edge_time_next;
  logic [BITS_W-1:0]     received_bits, received_bits_next;
  logic [31:0]           last_good_time, last_good_time_next;
  logic                  last_good_valid, last_good_valid_next;

  logic [SENSOR_SLOTS-1:0] mask_ext;
  logic [31:0] since_good, since_start, since_edge;
  logic [7:0]  b0, b1, b2, b3, b4, sum;
  logic        bit_val;

  assign mask_ext    = SENSOR_SLOTS'(enable_mask);
  assign since_good  = item.time_us - last_good_time;
  assign since_start = item.time_us - start_time;
  assign since_edge  = item.time_us - previous_edge_time;
  assign bit_val     = since_edge > {24'd0, one_bit_threshold};

  assign b0  = received_bits[39:32];
  assign b1  = received_bits[31:24];
  assign b2  = received_bits[23:16];
  assign b3  = received_bits[15:8];
  assign b4  = received_bits[7:0];
  assign sum = b0 + b1 + b2 + b3;

  always_comb begin
    collecting_next         = collecting;
    active_sensor_next      = active_sensor;
    start_time_next         = start_time;
    edge_count_next         = edge_count;
    previous_edge_time_next = previous_edge_time;
    received_bits_next      = received_bits;
    last_good_time_next     = last_good_time;
    last_good_valid_next    = last_good_valid;
    has_result              = 1'b0;
    result_next             = '0;
    case (item.cmd)
      CMD_START: begin
        has_result = 1'b1;
        if (collecting) begin
          result_next.status = ST_BUSY;
        end else if (!mask_ext[item.sensor_slot]) begin
          result_next.status = ST_IO;
        end else if (last_good_valid && item.sensor_slot == active_sensor &&
                     since_good < min_interval) begin
          result_next.status = ST_TOO_SOON;
        end else begin
          result_next.status = ST_STARTED;
          collecting_next    = 1'b1;
          active_sensor_next = item.sensor_slot;
          start_time_next    = item.time_us;
          edge_count_next    = EDGE_CNT_W'(1);
          received_bits_next = '0;
        end
      end
      CMD_EDGE: begin
        if (collecting && item.sensor_slot == active_sensor &&
            !(edge_count == EDGE_CNT_W'(1) && since_start < {20'd0, start_gap}) &&
            edge_count < EDGE_CNT_W'(EDGE_TOTAL)) begin
          // third accepted edge onward carries a data bit
          if (edge_count >= EDGE_CNT_W'(3)) begin
            received_bits_next = {received_bits[BITS_W-2:0], bit_val};
          end
          previous_edge_time_next = item.time_us;
          edge_count_next         = edge_count + EDGE_CNT_W'(1);
        end
      end
      CMD_FINISH: begin
        has_result = 1'b1;
        if (!collecting) begin
          result_next.status = ST_IO;
        end else begin
          collecting_next = 1'b0;
          if (edge_count < EDGE_CNT_W'(EDGE_TOTAL)) begin
            result_next.status = ST_IO;
          end else if (sum != b4) begin
            result_next.status = ST_CHECKSUM;
          end else begin
            result_next.status               = ST_OK;
            result_next.humidity_tenths      = {b0, b1};
            result_next.temperature_tenths   = {b2[6:0] & TEMP_MAG_MASK[6:0], b3};
            result_next.temperature_negative = |(b2 & TEMP_SIGN_MASK);
            last_good_time_next              = previous_edge_time;
            last_good_valid_next             = 1'b1;
          end
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask       <= '0;
      one_bit_threshold <= THRESHOLD_RESET;
      start_gap         <= START_GAP_RESET;
      min_interval      <= MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE_MASK:  enable_mask       <= cfg_data[NUM_SENSORS-1:0];
        REG_THRESHOLD:    one_bit_threshold <= cfg_data[7:0];
        REG_START_GAP:    start_gap         <= cfg_data[11:0];
        REG_MIN_INTERVAL: min_interval      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting         <= 1'b0;
      active_sensor      <= '0;
      start_time         <= '0;
      edge_count         <= '0;
      previous_edge_time <= '0;
      received_bits      <= '0;
      last_good_time     <= '0;
      last_good_valid    <= 1'b0;
    end else if (go) begin
      collecting         <= collecting_next;
      active_sensor      <= active_sensor_next;
      start_time         <= start_time_next;
      edge_count         <= edge_count_next;
      previous_edge_time <= previous_edge_time_next;
      received_bits      <= received_bits_next;
      last_good_time     <= last_good_time_next;
      last_good_valid    <= last_good_valid_next;
    end
  end

endmodule

FILE: sim/tb_single_wire_sensor_pulse_decoder.sv
// Self-checking testbench for the single-wire sensor pulse decoder: framed reads, noise, config sweeps.
module tb_single_wire_sensor_pulse_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import swpd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SENSORS = NUM_SENSORS_DEFAULT;
  localparam int IDLE_GAP = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  item_t pending_items[$];
  result_t expected_readings[$];
  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  int n_fail = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_counted = 0;

  // stimulus-side view of the current register values
  logic [31:0] t_now = 32'd1000;
  logic [7:0] cur_mask = '0;
  logic [7:0] cur_thresh = THRESHOLD_RESET;
  logic [11:0] cur_gap = START_GAP_RESET;

  // decoder state as predicted by the testbench
  logic [7:0] dec_enable = '0;
  logic [7:0] dec_threshold = THRESHOLD_RESET;
  logic [11:0] dec_gap = START_GAP_RESET;
  logic [31:0] dec_interval = MIN_INTERVAL_RESET;
  logic dec_busy = 1'b0;
  logic [2:0] dec_slot = '0;
  logic [31:0] dec_start_t = '0;
  logic [EDGE_CNT_W-1:0] dec_edges = '0;
  logic [31:0] dec_prev_t = '0;
  logic [BITS_W-1:0] dec_bits = '0;
  logic [31:0] dec_good_t = '0;
  logic dec_good_seen = 1'b0;

  single_wire_sensor_pulse_decoder i_dut (
    .clk,
    .rst,
    .item_valid,
    .item_ready,
    .item,
    .result_valid,
    .result_ready,
    .result,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  always #5ns clk = ~clk;

  function automatic void decode_item(input item_t it, output bit has_res, output result_t r);
    logic [31:0] dt;
    logic [7:0] b0, b1, b2, b3, b4, sum;
    has_res = 1'b0;
    r = '0;
    case (it.cmd)
      CMD_START: begin
        has_res = 1'b1;
        dt = it.time_us - dec_good_t;
        if (dec_busy) begin
          r.status = ST_BUSY;
        end else if (it.sensor_slot >= SENSORS || !dec_enable[it.sensor_slot]) begin
          r.status = ST_IO;
        end else if (dec_good_seen && it.sensor_slot == dec_slot && dt < dec_interval) begin
          r.status = ST_TOO_SOON;
        end else begin
          dec_busy = 1'b1;
          dec_slot = it.sensor_slot;
          dec_start_t = it.time_us;
          dec_edges = EDGE_CNT_W'(1);
          dec_bits = '0;
          r.status = ST_STARTED;
        end
      end
      CMD_EDGE: begin
        if (dec_busy && it.sensor_slot == dec_slot) begin
          dt = it.time_us - dec_start_t;
          if (!(dec_edges == EDGE_CNT_W'(1) && dt < {20'd0, dec_gap}) &&
              dec_edges < EDGE_CNT_W'(EDGE_TOTAL)) begin
            // third accepted edge onward carries one bit, MSB first
            if (dec_edges >= EDGE_CNT_W'(3)) begin
              dt = it.time_us - dec_prev_t;
              dec_bits = {dec_bits[BITS_W-2:0], dt > {24'd0, dec_threshold}};
            end
            dec_prev_t = it.time_us;
            dec_edges = dec_edges + EDGE_CNT_W'(1);
          end
        end
      end
      CMD_FINISH: begin
        has_res = 1'b1;
        if (!dec_busy) begin
          r.status = ST_IO;
        end else begin
          dec_busy = 1'b0;
          if (dec_edges < EDGE_CNT_W'(EDGE_TOTAL)) begin
            r.status = ST_IO;
          end else begin
            {b0, b1, b2, b3, b4} = dec_bits;
            sum = b0 + b1 + b2 + b3;
            if (sum != b4) begin
              r.status = ST_CHECKSUM;
            end else begin
              dec_good_t = dec_prev_t;
              dec_good_seen = 1'b1;
              r.status = ST_OK;
              r.humidity_tenths = {b0, b1};
              r.temperature_tenths = {b2[6:0], b3};
              r.temperature_negative = b2[7];
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // monitor: register writes, input transfers into the predictor, result checks
  always @(posedge clk) begin : monitor
    result_t want;
    bit has_res;
    if (!rst) begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_ENABLE_MASK:  dec_enable = cfg_data[7:0];
          REG_THRESHOLD:    dec_threshold = cfg_data[7:0];
          REG_START_GAP:    dec_gap = cfg_data[11:0];
          REG_MIN_INTERVAL: dec_interval = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_readings.size() == 0) begin
          n_fail++;
          $display("%0t: result with none expected: status %0d hum %0d temp %0d neg %0d",
                   $time, result.status, result.humidity_tenths, result.temperature_tenths,
                   result.temperature_negative);
        end else begin
          want = expected_readings.pop_front();
          if (result.status !== want.status ||
              result.humidity_tenths !== want.humidity_tenths ||
              result.temperature_tenths !== want.temperature_tenths ||
              result.temperature_negative !== want.temperature_negative) begin
            n_fail++;
            $display("%0t: mismatch: expected status %0d hum %0d temp %0d neg %0d, %s",
                     $time, want.status, want.humidity_tenths, want.temperature_tenths,
                     want.temperature_negative, "got");
            $display("%0t:           actual   status %0d hum %0d temp %0d neg %0d",
                     $time, result.status, result.humidity_tenths, result.temperature_tenths,
                     result.temperature_negative);
          end
        end
      end
      if (item_valid && item_ready) begin
        decode_item(item, has_res, want);
        n_accepted++;
        if (has_res) expected_readings.push_back(want);
      end
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [2:0] slot,
                           input logic [31:0] t, input bit counts);
    item_t it;
    it.cmd = cmd;
    it.sensor_slot = slot;
    it.time_us = t;
    pending_items.push_back(it);
    n_queued++;
    if (counts) n_counted++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] mask, input logic [7:0] thresh,
                            input logic [11:0] gap, input logic [31:0] interval);
    write_reg(REG_ENABLE_MASK, {24'd0, mask});
    write_reg(REG_THRESHOLD, {24'd0, thresh});
    write_reg(REG_START_GAP, {20'd0, gap});
    write_reg(REG_MIN_INTERVAL, interval);
    cur_mask = mask;
    cur_thresh = thresh;
    cur_gap = gap;
  endtask

  // block until every item is taken and every reading has come, then let it settle
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_readings.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // one read transaction: start, edges, finish; sometimes broken, with noise mixed in
  task automatic queue_read(input logic [2:0] slot);
    logic [7:0] b0, b1, b2, b3, b4;
    logic [39:0] frame;
    int kind;
    int n_edges;
    logic [31:0] w;
    bit one;
    kind = $urandom_range(99);
    {b0, b1, b2, b3} = $urandom;
    case ($urandom_range(15))
      0: {b0, b1, b2, b3} = '1;
      1: {b0, b1, b2, b3} = '0;
      default: ;
    endcase
    b4 = b0 + b1 + b2 + b3;
    if (kind >= 65 && kind < 78) b4 = b4 ^ 8'($urandom_range(255, 1));
    frame = {b0, b1, b2, b3, b4};
    n_edges = 42;
    if (kind >= 78 && kind < 88) n_edges = $urandom_range(41, 0);
    else if (kind >= 88) n_edges = 42 + $urandom_range(4, 1);
    push_item(CMD_START, slot, t_now, 1);
    // edge inside the start gap, dropped
    if (cur_gap != 0 && $urandom_range(4) == 0)
      push_item(CMD_EDGE, slot, t_now + $urandom_range(cur_gap - 1, 0), 1);
    for (int e = 1; e <= n_edges; e++) begin
      if (e == 1) begin
        w = cur_gap + $urandom_range(60, 0);
      end else if (e == 2) begin
        w = $urandom_range(200, 80);
      end else begin
        one = (e <= 42) ? frame[42-e] : 1'($urandom_range(1));
        if ($urandom_range(7) == 0) w = cur_thresh + one;
        else if (one) w = cur_thresh + 1 + $urandom_range(70, 0);
        else w = $urandom_range(cur_thresh, 0);
      end
      t_now += w;
      push_item(CMD_EDGE, slot, t_now, 1);
      case ($urandom_range(49))
        0, 1: push_item(CMD_EDGE, slot ^ 3'($urandom_range(7, 1)), $urandom, 0);
        2: push_item(CMD_START, 3'($urandom_range(7)), t_now, 1);
        3: push_item(CMD_UNUSED, 3'($urandom), $urandom, 0);
        default: ;
      endcase
    end
    t_now += $urandom_range(5000, 50);
    push_item(CMD_FINISH, 3'($urandom_range(7)), t_now, 1);
  endtask

  task automatic run_phase(input int n_items, input bit hold_mid);
    int first;
    bit held;
    logic [2:0] slot;
    first = n_counted;
    held = 1'b0;
    slot = '0;
    while (n_counted - first < n_items) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 1))
          push_item(2'($urandom_range(3)), 3'($urandom), $urandom, 1);
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: t_now += $urandom_range(3000, 10);
          5, 6, 7: t_now += $urandom_range(3_000_000, 2_000_000);
          default: t_now += $urandom;
        endcase
        if ($urandom_range(9) >= 4) begin
          if ($urandom_range(9) < 8 && cur_mask != 0) begin
            do slot = 3'($urandom); while (!cur_mask[slot]);
          end else begin
            slot = 3'($urandom);
          end
        end
        queue_read(slot);
      end
      if (hold_mid && !held && n_counted - first >= n_items / 2) begin
        held = 1'b1;
        wait_idle();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset config: every slot disabled
    push_item(CMD_START, 3'd3, 32'd0, 1);
    push_item(CMD_FINISH, 3'd0, 32'hFFFF_FFFF, 1);
    push_item(CMD_EDGE, 3'd7, 32'd0, 1);
    push_item(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 1);
    wait_idle();

    set_config(8'hFF, THRESHOLD_RESET, START_GAP_RESET, MIN_INTERVAL_RESET);
    push_item(CMD_START, 3'd7, 32'hFFFF_FF00, 1);
    push_item(CMD_START, 3'd0, 32'hFFFF_FF01, 1);
    push_item(CMD_EDGE, 3'd7, 32'hFFFF_FF0A, 1);
    push_item(CMD_EDGE, 3'd2, 32'd0, 1);
    push_item(CMD_FINISH, 3'd7, 32'd0, 1);
    push_item(CMD_START, 3'd0, 32'd0, 1);
    push_item(CMD_FINISH, 3'd0, 32'd10, 1);
    push_item(CMD_FINISH, 3'd5, 32'd20, 1);
    push_item(CMD_UNUSED, 3'd0, 32'd0, 1);
    wait_idle();

    run_phase(460, 1'b0);
    wait_idle();

    send_idle_pct = 67;
    set_config(8'($urandom_range(255, 1)), 8'd0, 12'd0, 32'd0);
    run_phase(460, 1'b1);
    wait_idle();

    send_idle_pct = 0;
    ready_stall_pct = 67;
    set_config(8'h81, 8'hFF, 12'hFFF, 32'hFFFF_FFFF);
    run_phase(460, 1'b0);
    wait_idle();

    send_idle_pct = 32;
    ready_stall_pct = 32;
    set_config(8'($urandom_range(255, 1)), 8'($urandom), 12'($urandom),
               $urandom_range(4_000_000));
    run_phase(460, 1'b0);
    wait_idle();

    if (n_fail == 0) begin
      $display("tb_single_wire_sensor_pulse_decoder passed");
    end else begin
      $display("tb_single_wire_sensor_pulse_decoder failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_single_wire_sensor_pulse_decoder failed");
    $finish;
  end

endmodule
